/* rtl/acl_pkg.sv */
// Shared types, codes and helpers for the connection ACL matcher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package acl_pkg;

  // Rules per list; allow rules sit in entries 0..MAX_RULES-1, deny rules above.
  localparam int MAX_RULES   = 16;
  localparam int TOTAL_RULES = 2 * MAX_RULES;
  localparam int IDX_W       = (TOTAL_RULES > 1) ? $clog2(TOTAL_RULES) : 1;
  localparam int CNT_W       = $clog2(MAX_RULES + 1);
  localparam int SCAN_W      = $clog2(TOTAL_RULES + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] IPV4_MAX_PREFIX = 8'd32;
  localparam logic [7:0] IPV6_MAX_PREFIX = 8'd128;

  typedef enum logic [1:0] {
    MODE_ALLOW = 2'd0,
    MODE_DENY  = 2'd1,
    MODE_CHECK = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    KIND_ANY      = 4'd0,
    KIND_ANY_V4   = 4'd1,
    KIND_ANY_V6   = 4'd2,
    KIND_IPV4     = 4'd3,
    KIND_IPV6     = 4'd4,
    KIND_ANY_UNIX = 4'd5,
    KIND_PID      = 4'd6,
    KIND_UID      = 4'd7,
    KIND_GID      = 4'd8,
    KIND_ANY_VSOCK = 4'd9,
    KIND_CID      = 4'd10,
    KIND_PORT     = 4'd11
  } kind_t;

  typedef enum logic [2:0] {
    FAM_UNIX    = 3'd0,
    FAM_IPV4    = 3'd1,
    FAM_IPV6    = 3'd2,
    FAM_VSOCK   = 3'd3,
    FAM_UNAVAIL = 3'd4,
    FAM_OTHER   = 3'd5
  } fam_t;

  typedef enum logic [2:0] {
    OP_APPEND,
    OP_REJECT,
    OP_CHECK,
    OP_UNAVAIL,
    OP_CLEAR
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    LIST_NONE  = 2'd0,
    LIST_ALLOW = 2'd1,
    LIST_DENY  = 2'd2
  } list_t;

  // Classified item as it waits in the queue
  typedef struct packed {
    op_t         op;
    logic        deny;      // target list of an append
    kind_t       kind;
    fam_t        family;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
    logic [31:0] id;
    logic [32:0] pid;
    logic [32:0] uid;
    logic [32:0] gid;
    logic [31:0] cid;
    logic [31:0] port;
  } item_t;

  // Stored rule: prefix kept as ready-made masks
  typedef struct packed {
    kind_t       kind;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [63:0] mask_hi;
    logic [63:0] mask_lo;
    logic [31:0] id;
  } rule_t;

  // Queue status toward the back end
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // Ones in the top bits positions of a 64-bit word
  function automatic logic [63:0] left_mask(input logic [7:0] bits);
    logic [63:0] m;
    if (bits == 8'd0) begin
      m = '0;
    end else if (bits >= 8'd64) begin
      m = '1;
    end else begin
      m = ~64'd0 << (7'd64 - bits[6:0]);
    end
    return m;
  endfunction

endpackage

/* rtl/acl_front.sv */
// Front end: accepts items and classifies them (rule checks, masks).
// Depends on acl_pkg.
`timescale 1ns / 1ps

module acl_front
  import acl_pkg::*;
(
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [3:0]         rule_kind,
  input  logic [2:0]         family,
  input  logic [63:0]        addr_hi,
  input  logic [63:0]        addr_lo,
  input  logic [7:0]         prefix_len,
  input  logic [31:0]        rule_id,
  input  logic signed [32:0] peer_pid,
  input  logic signed [32:0] peer_uid,
  input  logic signed [32:0] peer_gid,
  input  logic [31:0]        vsock_cid,
  input  logic [31:0]        vsock_port,
  input  q_stat_t            q_stat,
  output logic               push,
  output item_t              push_item
);

  logic [63:0] mask_top;
  logic [63:0] mask_low;
  logic        bad_rule;
  kind_t       kind;

  assign kind     = kind_t'(rule_kind);
  assign busy     = q_stat.full;
  assign push     = start && !q_stat.full;
  assign mask_top = left_mask(prefix_len);
  assign mask_low = (prefix_len > 8'd64) ? left_mask(prefix_len - 8'd64) : '0;

  // Flag appends whose kind or value is out of range
  always_comb begin
    bad_rule = 1'b0;
    if (rule_kind > 4'(KIND_PORT)) bad_rule = 1'b1;
    if (kind == KIND_IPV4 && prefix_len > IPV4_MAX_PREFIX) bad_rule = 1'b1;
    if (kind == KIND_IPV6 && prefix_len > IPV6_MAX_PREFIX) bad_rule = 1'b1;
    if (kind == KIND_PID && rule_id == 32'd0) bad_rule = 1'b1;
  end

  // Build the classified item
  always_comb begin
    push_item         = '0;
    push_item.kind    = kind;
    push_item.family  = fam_t'(family);
    push_item.addr_hi = addr_hi;
    push_item.addr_lo = addr_lo;
    push_item.id      = rule_id;
    push_item.pid     = peer_pid;
    push_item.uid     = peer_uid;
    push_item.gid     = peer_gid;
    push_item.cid     = vsock_cid;
    push_item.port    = vsock_port;
    push_item.deny    = (mode_t'(mode) == MODE_DENY);
    case (kind)
      KIND_IPV4: begin
        push_item.mask_lo = {32'd0, mask_top[63:32]};
      end
      KIND_IPV6: begin
        push_item.mask_hi = mask_top;
        push_item.mask_lo = mask_low;
      end
      default: begin
      end
    endcase
    case (mode_t'(mode))
      MODE_ALLOW, MODE_DENY: push_item.op = bad_rule ? OP_REJECT : OP_APPEND;
      MODE_CHECK: push_item.op = (fam_t'(family) == FAM_UNAVAIL) ? OP_UNAVAIL : OP_CHECK;
      MODE_CLEAR: push_item.op = OP_CLEAR;
      default:    push_item.op = OP_CLEAR;
    endcase
  end

endmodule

/* rtl/acl_queue.sv */
// Short item queue between the front end and the back end.
// Depends on acl_pkg (item type, depth).
`timescale 1ns / 1ps

module acl_queue
  import acl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   head,
  output q_stat_t q_stat
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QW = $clog2(QUEUE_DEPTH + 1);

  item_t         slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [QW-1:0] fill;

  assign head         = slots[rd_ptr];
  assign q_stat.empty = (fill == '0);
  assign q_stat.full  = (fill == QW'(QUEUE_DEPTH));

  // Store incoming items
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/acl_back.sv */
// Back end: rule storage, appends, clears and the ordered rule scan.
// Depends on acl_pkg; takes items from acl_queue.
`timescale 1ns / 1ps

module acl_back
  import acl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  item_t      head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       done,
  output logic       allowed,
  output logic [1:0] matched_list,
  output logic [3:0] matched_index,
  output logic [1:0] status
);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t            state;
  rule_t             mem [TOTAL_RULES];
  rule_t             rd_rule;
  item_t             cur;
  logic [CNT_W-1:0]  allow_count;
  logic [CNT_W-1:0]  deny_count;
  logic [SCAN_W-1:0] sidx;
  logic              rv;
  logic              rv_deny;
  logic [3:0]        rv_idx;

  logic              head_full;
  logic [CNT_W-1:0]  head_count;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic              in_deny;
  logic [SCAN_W-1:0] local_idx;
  logic [SCAN_W-1:0] limit;
  logic              issue_ok;
  logic              hit;
  logic              prefix_ok;

  assign pop = (state == S_IDLE) && !q_stat.empty;

  // Append target and fullness of its list
  assign head_count = head.deny ? deny_count : allow_count;
  assign head_full  = (head_count == CNT_W'(MAX_RULES));
  assign mem_we     = pop && (head.op == OP_APPEND) && !head_full;
  assign mem_wa     = head.deny ? IDX_W'(MAX_RULES) + IDX_W'(head_count)
                                : IDX_W'(head_count);

  // Rule table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= '{kind: head.kind, addr_hi: head.addr_hi, addr_lo: head.addr_lo,
                       mask_hi: head.mask_hi, mask_lo: head.mask_lo, id: head.id};
    end
  end

  always_ff @(posedge clk) begin
    rd_rule <= mem[sidx[IDX_W-1:0]];
  end

  // Decide whether the scan position holds a live rule
  assign in_deny   = (sidx >= SCAN_W'(MAX_RULES));
  assign local_idx = in_deny ? sidx - SCAN_W'(MAX_RULES) : sidx;
  assign limit     = in_deny ? SCAN_W'(deny_count) : SCAN_W'(allow_count);
  assign issue_ok  = (sidx < SCAN_W'(TOTAL_RULES)) && (local_idx < limit);

  // Match the fetched rule against the client under test
  assign prefix_ok = (((cur.addr_hi ^ rd_rule.addr_hi) & rd_rule.mask_hi) == '0) &&
                     (((cur.addr_lo ^ rd_rule.addr_lo) & rd_rule.mask_lo) == '0);

  always_comb begin
    case (rd_rule.kind)
      KIND_ANY:       hit = 1'b1;
      KIND_ANY_V4:    hit = (cur.family == FAM_IPV4);
      KIND_ANY_V6:    hit = (cur.family == FAM_IPV6);
      KIND_IPV4:      hit = (cur.family == FAM_IPV4) && prefix_ok;
      KIND_IPV6:      hit = (cur.family == FAM_IPV6) && prefix_ok;
      KIND_ANY_UNIX:  hit = (cur.family == FAM_UNIX);
      KIND_PID:       hit = (cur.family == FAM_UNIX) && !cur.pid[32] &&
                            (cur.pid[31:0] == rd_rule.id);
      KIND_UID:       hit = (cur.family == FAM_UNIX) && !cur.uid[32] &&
                            (cur.uid[31:0] == rd_rule.id);
      KIND_GID:       hit = (cur.family == FAM_UNIX) && !cur.gid[32] &&
                            (cur.gid[31:0] == rd_rule.id);
      KIND_ANY_VSOCK: hit = (cur.family == FAM_VSOCK);
      KIND_CID:       hit = (cur.family == FAM_VSOCK) && (cur.cid == rd_rule.id);
      KIND_PORT:      hit = (cur.family == FAM_VSOCK) && (cur.port == rd_rule.id);
      default:        hit = 1'b0;
    endcase
  end

  // Sequencer: dispatch queued items, run the scan, drive the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      allow_count <= '0;
      deny_count  <= '0;
      sidx        <= '0;
      rv          <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            allowed       <= 1'b0;
            matched_list  <= LIST_NONE;
            matched_index <= '0;
            status        <= ST_OK;
            case (head.op)
              OP_APPEND: begin
                done <= 1'b1;
                if (head_full) begin
                  status <= ST_FULL;
                end else if (head.deny) begin
                  deny_count <= deny_count + 1'b1;
                end else begin
                  allow_count <= allow_count + 1'b1;
                end
              end
              OP_REJECT: begin
                done   <= 1'b1;
                status <= head_full ? ST_FULL : ST_RANGE;
              end
              OP_CLEAR: begin
                done        <= 1'b1;
                allow_count <= '0;
                deny_count  <= '0;
              end
              OP_CHECK: begin
                cur   <= head;
                sidx  <= '0;
                rv    <= 1'b0;
                state <= S_SCAN;
              end
              default: begin
                // peer name unavailable: deny outright
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (rv && hit) begin
            done          <= 1'b1;
            allowed       <= !rv_deny;
            matched_list  <= rv_deny ? LIST_DENY : LIST_ALLOW;
            matched_index <= rv_idx;
            status        <= ST_OK;
            rv            <= 1'b0;
            state         <= S_IDLE;
          end else if (sidx == SCAN_W'(TOTAL_RULES)) begin
            done          <= 1'b1;
            allowed       <= 1'b1;
            matched_list  <= LIST_NONE;
            matched_index <= '0;
            status        <= ST_OK;
            rv            <= 1'b0;
            state         <= S_IDLE;
          end else begin
            rv      <= issue_ok;
            rv_deny <= in_deny;
            rv_idx  <= 4'(local_idx);
            sidx    <= sidx + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/connection_acl_matcher.sv */
// Connection ACL matcher: allow/deny rule lists with ordered prefix matching.
// Appends, clears and unavailable-peer checks give a registered done once the back end pops
// them; a check scans the 2*MAX_RULES slots in order, allow list first, one per cycle, up to
// the first hit or the last slot. One append or clear per cycle while the queue is not full;
// a check holds the back end while a two-entry queue takes new items; results cannot be stalled.
// Reset (rst, synchronous) empties both lists and the queue; rule contents stay undefined.
`timescale 1ns / 1ps

module connection_acl_matcher
  import acl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [3:0]         rule_kind,
  input  logic [2:0]         family,
  input  logic [63:0]        addr_hi,
  input  logic [63:0]        addr_lo,
  input  logic [7:0]         prefix_len,
  input  logic [31:0]        rule_id,
  input  logic signed [32:0] peer_pid,
  input  logic signed [32:0] peer_uid,
  input  logic signed [32:0] peer_gid,
  input  logic [31:0]        vsock_cid,
  input  logic [31:0]        vsock_port,
  output logic               done,
  output logic               allowed,
  output logic [1:0]         matched_list,
  output logic [3:0]         matched_index,
  output logic [1:0]         status
);

  q_stat_t q_stat;
  item_t   push_item;
  item_t   head;
  logic    push;
  logic    pop;

  // Classify incoming items
  acl_front u_front (
    .start      (start),
    .busy       (busy),
    .mode       (mode),
    .rule_kind  (rule_kind),
    .family     (family),
    .addr_hi    (addr_hi),
    .addr_lo    (addr_lo),
    .prefix_len (prefix_len),
    .rule_id    (rule_id),
    .peer_pid   (peer_pid),
    .peer_uid   (peer_uid),
    .peer_gid   (peer_gid),
    .vsock_cid  (vsock_cid),
    .vsock_port (vsock_port),
    .q_stat     (q_stat),
    .push       (push),
    .push_item  (push_item)
  );

  // Buffer classified items
  acl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Execute items against the rule tables
  acl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .done          (done),
    .allowed       (allowed),
    .matched_list  (matched_list),
    .matched_index (matched_index),
    .status        (status)
  );

endmodule
